// File: rtl/lph_pkg.sv
// Shared types, widths and codes for the linear probing hash map.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lph_pkg;

    // Table geometry
    localparam int SLOTS        = 256;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int CAP_W        = SLOT_W + 1;
    localparam int KEY_W        = 21;
    localparam int PAYLOAD_BITS = 32;

    // Remainder unit: bits of the key retired per cycle
    localparam int MOD_RADIX_BITS = 3;
    localparam int MOD_STEPS      = (KEY_W + MOD_RADIX_BITS - 1) / MOD_RADIX_BITS;
    localparam int MOD_PAD_W      = MOD_STEPS * MOD_RADIX_BITS;
    localparam int MOD_CNT_W      = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    // Stream word widths, padded to whole bytes
    localparam int S_TDATA_W = ((KEY_W + PAYLOAD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((SLOT_W + PAYLOAD_BITS + CAP_W + 7) / 8) * 8;
    localparam int STATUS_W  = 3;

    // Opcodes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_MISS     = 3'd1,
        STAT_DUP      = 3'd2,
        STAT_FULL     = 3'd3,
        STAT_NO_TABLE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HOME,
        ST_PROBE,
        ST_COMPARE,
        ST_FINISH
    } lph_state_t;

    // One table entry
    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic [PAYLOAD_BITS-1:0] payload;
    } slot_entry_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        slot_entry_t       entry;
    } slot_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } slot_rd_t;

    // Remainder unit request and response
    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [CAP_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] rem;
    } mod_rsp_t;

endpackage

`default_nettype wire

// File: rtl/lph_mod_unit.sv
// Iterative remainder unit: key modulo capacity, a few key bits per cycle.
// Depends on lph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lph_mod_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lph_pkg::mod_req_t req,
    output lph_pkg::mod_rsp_t      rsp
);
    import lph_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [MOD_PAD_W-1:0] shift_reg;
    logic [CAP_W-1:0]     divisor_reg;
    logic [SLOT_W-1:0]    rem_reg;
    logic [SLOT_W-1:0]    rem_next;
    logic [SLOT_W-1:0]    part;
    logic [CAP_W-1:0]     wide;

    // Restoring remainder steps; the partial remainder stays below the divisor
    always_comb
    begin
        part = rem_reg;
        wide = '0;
        for (int i = 0; i < MOD_RADIX_BITS; i++)
        begin
            wide = {part, shift_reg[MOD_PAD_W-1-i]};
            if (wide >= divisor_reg)
            begin
                wide = wide - divisor_reg;
            end
            part = wide[SLOT_W-1:0];
        end
        rem_next = part;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + MOD_CNT_W'(1);
                if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            shift_reg   <= MOD_PAD_W'(req.dividend);
            divisor_reg <= req.divisor;
            rem_reg     <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << MOD_RADIX_BITS;
            rem_reg   <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

`default_nettype wire

// File: rtl/lph_slot_store.sv
// Slot storage: key/payload memory with registered read, plus occupancy flags.
// Depends on lph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lph_slot_store (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lph_pkg::slot_rd_t     rd,
    output lph_pkg::slot_entry_t       rd_entry,
    input  wire lph_pkg::slot_wr_t     wr,
    input  wire logic [lph_pkg::SLOT_W-1:0] occ_addr,
    output logic                       occ_bit
);
    import lph_pkg::*;

    slot_entry_t       mem [SLOTS];
    slot_entry_t       rd_data_reg;
    logic [SLOTS-1:0]  occ_reg;

    // Entry memory, one write and one read port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    // Occupancy flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (wr.en)
        begin
            occ_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_entry = rd_data_reg;
    assign occ_bit  = occ_reg[occ_addr];

endmodule

`default_nettype wire

// File: rtl/linear_probe_hash_map.sv
// Top level of the linear probing hash map: probe sequencer and output register.
// Depends on lph_pkg, lph_mod_unit and lph_slot_store.
//
// Usage:
//   s_* carries one operation word: s_tuser[0] is the opcode (0 lookup,
//   1 insert), s_tdata holds key and payload. m_* returns one result word
//   per operation: m_tuser holds the status, m_tdata slot, payload and the
//   entry count after the operation. cfg_* writes the capacity in use
//   (0 = no table, values above 256 act as 256); write it only while idle.
//   Timing: one operation at a time. The home slot comes from an iterative
//   remainder unit, then each occupied slot passed costs a flag check
//   followed by a memory read and key compare. A no-table word goes
//   straight to the result without the remainder unit or a probe. The
//   next word is accepted the cycle after the result is registered.
//   Reset clears all occupancy flags, the entry count and sets capacity to
//   256; no clearing pass is needed. A stalled receiver holds the result in
//   the output register; one finished result may wait there while the next
//   word is processed, and the sequencer waits only if a second one is done.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_map (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // s_tdata: [20:0] key, [52:21] payload_in, zero fill above
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [lph_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: [0] opcode
    input  wire logic [0:0]                    s_tuser,
    // m_tdata: [7:0] slot, [39:8] payload_out, [48:40] entry_count, zero fill above
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [lph_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: [2:0] status
    output logic [lph_pkg::STATUS_W-1:0]       m_tuser,
    // capacity write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lph_pkg::CAP_W-1:0]     cfg_data
);
    import lph_pkg::*;

    lph_state_t              state_reg, state_next;
    logic                    op_reg, op_next;
    logic [KEY_W-1:0]        key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [CAP_W-1:0]        cap_item_reg, cap_item_next;
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic [SLOT_W-1:0]       home_reg, home_next;
    logic [CAP_W-1:0]        probe_cnt_reg, probe_cnt_next;
    status_t                 res_status_reg, res_status_next;
    logic [SLOT_W-1:0]       res_slot_reg, res_slot_next;
    logic [PAYLOAD_BITS-1:0] res_payload_reg, res_payload_next;
    logic [CAP_W-1:0]        total_reg, total_next;
    logic [CAP_W-1:0]        cap_reg;

    logic                    m_valid_reg;
    status_t                 m_status_reg;
    logic [SLOT_W-1:0]       m_slot_reg;
    logic [PAYLOAD_BITS-1:0] m_payload_reg;
    logic [CAP_W-1:0]        m_count_reg;

    logic                    s_accept;
    logic                    out_load;
    logic [CAP_W-1:0]        cap_sat;
    logic [CAP_W-1:0]        idx_inc;
    mod_req_t                mod_req;
    mod_rsp_t                mod_rsp;
    slot_rd_t                rd;
    slot_wr_t                wr;
    slot_entry_t             rd_entry;
    logic                    occ_bit;

    lph_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    lph_slot_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .rd_entry (rd_entry),
        .wr       (wr),
        .occ_addr (idx_reg),
        .occ_bit  (occ_bit)
    );

    // Capacity register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(SLOTS);
        end
        else if (cfg_valid)
        begin
            cap_reg <= cfg_data;
        end
    end

    assign cap_sat  = (cap_reg > CAP_W'(SLOTS)) ? CAP_W'(SLOTS) : cap_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign idx_inc  = {1'b0, idx_reg} + CAP_W'(1);

    // Probe sequencer
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        pay_next         = pay_reg;
        cap_item_next    = cap_item_reg;
        idx_next         = idx_reg;
        home_next        = home_reg;
        probe_cnt_next   = probe_cnt_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_payload_next = res_payload_reg;
        total_next       = total_reg;
        out_load         = 1'b0;
        mod_req          = '0;
        rd               = '0;
        wr               = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next       = s_tuser[0];
                    key_next      = s_tdata[KEY_W-1:0];
                    pay_next      = s_tdata[KEY_W +: PAYLOAD_BITS];
                    cap_item_next = cap_sat;
                    if (cap_sat == '0)
                    begin
                        res_status_next  = STAT_NO_TABLE;
                        res_slot_next    = '0;
                        res_payload_next = '0;
                        state_next       = ST_FINISH;
                    end
                    else
                    begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = s_tdata[KEY_W-1:0];
                        mod_req.divisor  = cap_sat;
                        state_next       = ST_HOME;
                    end
                end
            end

            ST_HOME:
            begin
                if (mod_rsp.done)
                begin
                    idx_next       = mod_rsp.rem;
                    home_next      = mod_rsp.rem;
                    probe_cnt_next = '0;
                    state_next     = ST_PROBE;
                end
            end

            ST_PROBE:
            begin
                if (!occ_bit)
                begin
                    // empty slot ends the probe
                    res_slot_next    = idx_reg;
                    res_payload_next = '0;
                    if (op_reg == OP_INSERT)
                    begin
                        wr.en            = 1'b1;
                        wr.addr          = idx_reg;
                        wr.entry.key     = key_reg;
                        wr.entry.payload = pay_reg;
                        if (total_reg < CAP_W'(SLOTS))
                        begin
                            total_next = total_reg + CAP_W'(1);
                        end
                        res_status_next = STAT_OK;
                    end
                    else
                    begin
                        res_status_next = STAT_MISS;
                    end
                    state_next = ST_FINISH;
                end
                else
                begin
                    rd.en      = 1'b1;
                    rd.addr    = idx_reg;
                    state_next = ST_COMPARE;
                end
            end

            ST_COMPARE:
            begin
                if (rd_entry.key == key_reg)
                begin
                    res_slot_next = idx_reg;
                    if (op_reg == OP_INSERT)
                    begin
                        res_status_next  = STAT_DUP;
                        res_payload_next = '0;
                    end
                    else
                    begin
                        res_status_next  = STAT_OK;
                        res_payload_next = rd_entry.payload;
                    end
                    state_next = ST_FINISH;
                end
                else if (probe_cnt_reg + CAP_W'(1) == cap_item_reg)
                begin
                    // full sweep without a match or a hole
                    res_slot_next    = home_reg;
                    res_payload_next = '0;
                    res_status_next  = (op_reg == OP_INSERT) ? STAT_FULL : STAT_MISS;
                    state_next       = ST_FINISH;
                end
                else
                begin
                    idx_next       = (idx_inc == cap_item_reg) ? '0 : idx_inc[SLOT_W-1:0];
                    probe_cnt_next = probe_cnt_reg + CAP_W'(1);
                    state_next     = ST_PROBE;
                end
            end

            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
        end
    end

    // Item and result holding registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        pay_reg         <= pay_next;
        cap_item_reg    <= cap_item_next;
        idx_reg         <= idx_next;
        home_reg        <= home_next;
        probe_cnt_reg   <= probe_cnt_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        res_payload_reg <= res_payload_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_status_reg  <= res_status_reg;
            m_slot_reg    <= res_slot_reg;
            m_payload_reg <= res_payload_reg;
            m_count_reg   <= total_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = M_TDATA_W'({m_count_reg, m_payload_reg, m_slot_reg});

    // Checks
    a_mod_done_home: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> state_reg == ST_HOME)
        else $error("remainder finished outside home wait");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= CAP_W'(SLOTS))
        else $error("entry count above table size");

    a_write_empty: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !occ_bit)
        else $error("insert overwrote an occupied slot");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE || state_reg == ST_COMPARE) |->
            (probe_cnt_reg < cap_item_reg && {1'b0, idx_reg} < cap_item_reg))
        else $error("probe left the capacity in use");

    a_no_table: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && cap_sat == '0) |=> state_reg == ST_FINISH)
        else $error("no-table word did not finish at once");

endmodule

`default_nettype wire
